/* sv/assert_macros.svh */
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define GTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define GTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/gtp_pkg.sv */
`timescale 1ns / 1ps

package gtp_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_TARGET_ANGLE = 3'd0,
    REG_PROP_GAIN    = 3'd1,
    REG_INTEG_GAIN   = 3'd2,
    REG_DERIV_GAIN   = 3'd3,
    REG_SETTLE_BAND  = 3'd4,
    REG_SLOW_LIMIT   = 3'd5
  } gtp_reg_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Reset values of the registers (gains are Q8.8)
  localparam logic signed [15:0] TARGET_ANGLE_RST = 16'sd0;
  localparam logic [15:0]        PROP_GAIN_RST    = 16'd90;
  localparam logic [15:0]        INTEG_GAIN_RST   = 16'd256;
  localparam logic [15:0]        DERIV_GAIN_RST   = 16'd384;
  localparam logic [14:0]        SETTLE_BAND_RST  = 15'd10;
  localparam logic signed [15:0] SLOW_LIMIT_RST   = 16'sd10;

  localparam logic [6:0]  DRIVE_MAX    = 7'd127;
  localparam logic [15:0] INTEG_MAX    = 16'hFFFF;

  typedef struct packed {
    logic signed [15:0] angle_sample;
    logic               first_sample;
  } gtp_in_t;

  typedef struct packed {
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
    logic              done_res;
  } gtp_out_t;

  typedef struct packed {
    logic signed [15:0] target_angle;
    logic [15:0]        prop_gain;
    logic [15:0]        integ_gain;
    logic [15:0]        deriv_gain;
    logic [14:0]        settle_band;
    logic signed [15:0] slow_limit;
  } gtp_cfg_t;

  typedef struct packed {
    logic signed [15:0] last_angle;
    logic [15:0]        integral_count;
    logic               finished;
  } gtp_state_t;

endpackage

/* sv/gtp_cfg_regs.sv */
`timescale 1ns / 1ps

module gtp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [gtp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gtp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output gtp_pkg::gtp_cfg_t              cfg
);
  import gtp_pkg::*;

  // Decode the index and load the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_angle <= TARGET_ANGLE_RST;
      cfg.prop_gain    <= PROP_GAIN_RST;
      cfg.integ_gain   <= INTEG_GAIN_RST;
      cfg.deriv_gain   <= DERIV_GAIN_RST;
      cfg.settle_band  <= SETTLE_BAND_RST;
      cfg.slow_limit   <= SLOW_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TARGET_ANGLE: cfg.target_angle <= $signed(cfg_data);
        REG_PROP_GAIN:    cfg.prop_gain    <= cfg_data;
        REG_INTEG_GAIN:   cfg.integ_gain   <= cfg_data;
        REG_DERIV_GAIN:   cfg.deriv_gain   <= cfg_data;
        REG_SETTLE_BAND:  cfg.settle_band  <= cfg_data[14:0];
        REG_SLOW_LIMIT:   cfg.slow_limit   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

/* sv/gtp_step.sv */
`timescale 1ns / 1ps

module gtp_step (
  input  gtp_pkg::gtp_cfg_t   cfg,
  input  gtp_pkg::gtp_in_t    word,
  input  gtp_pkg::gtp_state_t cur,
  output gtp_pkg::gtp_state_t nxt,
  output gtp_pkg::gtp_out_t   res
);
  import gtp_pkg::*;

  logic               idle;
  logic signed [15:0] prev_angle;
  logic [15:0]        integ_base;
  logic signed [16:0] err;
  logic signed [16:0] vel;
  logic               grow;
  logic [15:0]        integ_new;
  logic signed [33:0] p_err;
  logic [31:0]        p_int;
  logic signed [33:0] p_vel;
  logic [35:0]        acc;
  logic [35:0]        mag;
  logic [6:0]         drive_mag;
  logic [7:0]         drive;
  logic [16:0]        aerr;
  logic               settled;

  // A first word restarts the move from a cleared history
  assign idle       = !word.first_sample && cur.finished;
  assign prev_angle = word.first_sample ? 16'sd0 : cur.last_angle;
  assign integ_base = word.first_sample ? 16'd0 : cur.integral_count;

  // Error and velocity, one bit wider than the operands
  assign err = {cfg.target_angle[15], cfg.target_angle}
             - {word.angle_sample[15], word.angle_sample};
  assign vel = {word.angle_sample[15], word.angle_sample}
             - {prev_angle[15], prev_angle};

  // Count up while slow and short of target, holding at INTEG_MAX; clear otherwise
  assign grow = (vel < $signed({cfg.slow_limit[15], cfg.slow_limit})) && (err > 17'sd0);
  always_comb begin
    if (!grow)
      integ_new = 16'd0;
    else if (integ_base == INTEG_MAX)
      integ_new = integ_base;
    else
      integ_new = integ_base + 16'd1;
  end

  // Three gain products, summed with the velocity term subtracted
  assign p_err = err * $signed({1'b0, cfg.prop_gain});
  assign p_int = integ_new * cfg.integ_gain;
  assign p_vel = vel * $signed({1'b0, cfg.deriv_gain});
  assign acc   = {{2{p_err[33]}}, p_err} + {4'd0, p_int} - {{2{p_vel[33]}}, p_vel};

  // Shift the magnitude, saturate, then restore the sign
  assign mag       = acc[35] ? (36'd0 - acc) : acc;
  assign drive_mag = (|mag[35:15]) ? DRIVE_MAX : mag[14:8];
  assign drive     = acc[35] ? (8'd0 - {1'b0, drive_mag}) : {1'b0, drive_mag};

  // Settled once the error is within the band
  assign aerr    = err[16] ? (17'd0 - err) : err;
  assign settled = aerr <= {2'd0, cfg.settle_band};

  // Finished moves hold state and give zero drive
  always_comb begin
    if (idle) begin
      nxt             = cur;
      res.left_drive  = 8'sd0;
      res.right_drive = 8'sd0;
      res.done_res    = 1'b1;
    end else begin
      nxt.last_angle     = word.angle_sample;
      nxt.integral_count = integ_new;
      nxt.finished       = settled;
      res.left_drive     = $signed(drive);
      res.right_drive    = $signed(8'd0 - drive);
      res.done_res       = settled;
    end
  end

endmodule

/* sv/gyro_turn_pid_controller_unit.sv */
`timescale 1ns / 1ps

// Gyro turn PID controller: takes one angle word per cycle and returns one
// drive word for it through the input register, then the result register,
// sustaining one word per cycle while the output side does not stall. The
// rate is set by the state update: error, velocity, integral count and the
// three Q8.8 gain products with their sum are worked out in one pass between
// the input and result registers. Configuration writes are taken at once
// (cfg_ready is always high) and should be made while idle.

module gyro_turn_pid_controller_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gtp_pkg::gtp_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gtp_pkg::gtp_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gtp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gtp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gtp_pkg::*;

  `include "assert_macros.svh"

  gtp_cfg_t   cfg;
  gtp_state_t state;
  gtp_state_t state_next;
  gtp_out_t   res_next;
  gtp_in_t    in_q;
  logic       in_q_valid;
  logic       advance;

  assign cfg_ready = 1'b1;

  gtp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gtp_step u_step (
    .cfg  (cfg),
    .word (in_q),
    .cur  (state),
    .nxt  (state_next),
    .res  (res_next)
  );

  // Advance when the result register is free or being drained
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_q_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  // Controller state, updated as each word moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.last_angle     <= 16'sd0;
      state.integral_count <= 16'd0;
      state.finished       <= 1'b1;
    end else if (in_q_valid && advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_q_valid && advance) begin
      out_data <= res_next;
    end
  end

  `GTP_ASSERT(a_sides_mirror, out_valid |-> (out_data.right_drive == -out_data.left_drive), "right drive is not the negation of left")
  `GTP_ASSERT(a_drive_range, out_valid |-> (out_data.left_drive != -8'sd128), "left drive outside saturation range")
  `GTP_ASSERT(a_done_tracks_state, out_valid |-> (out_data.done_res == state.finished), "done flag disagrees with finished state")
  `GTP_ASSERT(a_held_word_kept, (in_q_valid && !advance) |=> (in_q_valid && $stable(in_q)), "held input word lost or changed")

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import gtp_pkg::*;

  // Indexes past the last register: writes to these must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int IDLE_PCT      = 32;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_WORDS   = 110;
  localparam int WIND_UP_WORDS = 40;
  localparam int MAX_REPORTS   = 40;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  gtp_in_t                in_data;
  logic                   out_valid;
  logic                   out_stall;
  gtp_out_t               out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  gyro_turn_pid_controller_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Controller copy: registers and loop state
  logic signed [15:0] tgt_angle;
  logic [15:0]        kp_gain;
  logic [15:0]        ki_gain;
  logic [15:0]        kd_gain;
  logic [14:0]        band;
  logic signed [15:0] slow_lim;
  logic signed [15:0] prev_angle;
  logic [15:0]        integ_count;
  logic               move_over;

  gtp_out_t expected_drives[$];
  int       fails = 0;
  int       words_sent = 0;
  int       hold_left = 0;
  bit       calm = 1'b0;

  // Work out the drive word for one accepted angle word and advance the loop
  function automatic gtp_out_t predict_drive(gtp_in_t s);
    int       err;
    int       vel;
    int       aerr;
    int       drv;
    int       neg;
    longint   acc;
    longint   mag;
    longint   p;
    longint   i;
    longint   d;
    gtp_out_t r;
    if (s.first_sample) begin
      prev_angle  = '0;
      integ_count = '0;
      move_over   = 1'b0;
    end
    if (move_over) begin
      r.left_drive  = '0;
      r.right_drive = '0;
      r.done_res    = 1'b1;
      return r;
    end
    err = int'(tgt_angle) - int'($signed(s.angle_sample));
    vel = int'($signed(s.angle_sample)) - int'(prev_angle);
    // Grow the integral only while slow and short of the target
    if (vel < int'(slow_lim) && err > 0) begin
      if (integ_count != INTEG_MAX) integ_count = integ_count + 16'd1;
    end else begin
      integ_count = '0;
    end
    p = kp_gain;
    i = ki_gain;
    d = kd_gain;
    acc = longint'(err) * p + longint'(integ_count) * i - longint'(vel) * d;
    // Truncate toward zero on the magnitude, then clamp
    mag = (acc < 0) ? -acc : acc;
    mag = mag >> 8;
    if (mag > longint'(DRIVE_MAX)) mag = longint'(DRIVE_MAX);
    drv = (acc < 0) ? -int'(mag) : int'(mag);
    neg = -drv;
    aerr = (err < 0) ? -err : err;
    if (aerr <= int'(band)) move_over = 1'b1;
    prev_angle    = s.angle_sample;
    r.left_drive  = drv[7:0];
    r.right_drive = neg[7:0];
    r.done_res    = move_over;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("%0t ns: %s expected %0d actual %0d", $time, name, $signed(want),
                 $signed(got));
    end
  endfunction

  // Check each drive word against the oldest expectation
  always @(posedge clk) begin
    gtp_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_drives.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t ns: drive word expected none actual %0d/%0d/%0d", $time,
                   out_data.left_drive, out_data.right_drive, out_data.done_res);
      end else begin
        want = expected_drives.pop_front();
        compare_field("left_drive", want.left_drive, out_data.left_drive);
        compare_field("right_drive", want.right_drive, out_data.right_drive);
        compare_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
      end
    end
  end

  // Output side: random stalls, a counted hold-off on request, none while calm
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Offer one angle word, hold it until taken, then maybe idle a while
  task automatic send_sample(input logic signed [15:0] angle, input logic first);
    gtp_in_t s;
    int      gap;
    s.angle_sample = angle;
    s.first_sample = first;
    in_data  <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_drives.push_back(predict_drive(s));
    words_sent++;
    gap = 0;
    if (!calm) while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every drive word, then let the pipeline empty
  task automatic drain;
    in_valid <= 1'b0;
    wait (expected_drives.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TARGET_ANGLE: tgt_angle = data;
      REG_PROP_GAIN:    kp_gain   = data;
      REG_INTEG_GAIN:   ki_gain   = data;
      REG_DERIV_GAIN:   kd_gain   = data;
      REG_SETTLE_BAND:  band      = data[14:0];
      REG_SLOW_LIMIT:   slow_lim  = data;
      default: ;
    endcase
  endtask

  // Write every register, poke the spare indexes, then release the port
  task automatic set_all(input logic [15:0] t, input logic [15:0] p, input logic [15:0] i,
                         input logic [15:0] d, input logic [15:0] b, input logic [15:0] s);
    write_reg(REG_TARGET_ANGLE, t);
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_INTEG_GAIN, i);
    write_reg(REG_DERIV_GAIN, d);
    write_reg(REG_SETTLE_BAND, b);
    write_reg(REG_SLOW_LIMIT, s);
    write_reg(REG_SPARE_LO, 16'($urandom));
    write_reg(REG_SPARE_HI, 16'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(1023));
      1:       return 16'($urandom);
      2:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(64, 512));
    endcase
  endfunction

  function automatic logic [15:0] pick_target();
    case ($urandom_range(3))
      0, 1:    return 16'(int'($urandom_range(4000)) - 2000);
      2:       return 16'($urandom);
      default: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  function automatic logic [15:0] pick_band();
    case ($urandom_range(5))
      0:       return 16'($urandom);
      1:       return 16'h7FFF;
      default: return {1'($urandom), 15'($urandom_range(40))};
    endcase
  endfunction

  function automatic logic [15:0] pick_slow();
    case ($urandom_range(4))
      0:       return 16'($urandom);
      1:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'(int'($urandom_range(60)) - 20);
    endcase
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // One turn: start near zero and close in on the target with some jitter
  task automatic run_move;
    int pos;
    int tgt;
    int n;
    int step;
    tgt = int'(tgt_angle);
    pos = int'($urandom_range(100)) - 50;
    send_sample(16'(pos), 1'b1);
    n = $urandom_range(3, 30);
    repeat (n) begin
      step = (tgt - pos) / int'($urandom_range(2, 6)) + int'($urandom_range(8)) - 4;
      if ($urandom_range(19) == 0) step = int'($urandom_range(2000)) - 1000;
      pos = clamp16(pos + step);
      send_sample(16'(pos), 1'b0);
    end
  endtask

  task automatic test_idle_after_reset;
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
  endtask

  // Reset gains, target zero: overshoot, settle, then sit idle; restart on target
  task automatic test_settle_sequence;
    send_sample(16'sd100, 1'b1);
    send_sample(16'sd40, 1'b0);
    send_sample(-16'sd6, 1'b0);
    send_sample(-16'sd300, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd5, 1'b0);
    drain;
  endtask

  // Full-scale angles and gains drive both clamps; restart in mid-move
  task automatic test_drive_saturation;
    set_all(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h7FFF);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    drain;
    set_all(16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sd100, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd1, 1'b0);
    drain;
  endtask

  // Small negative sums must round toward zero, not down
  task automatic test_truncation;
    set_all(16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'sd300, 1'b1);
    send_sample(16'sd200, 1'b0);
    send_sample(-16'sd300, 1'b0);
    send_sample(16'sd255, 1'b0);
    drain;
  endtask

  // Hold the angle still far from target so the integral keeps climbing
  task automatic test_integral_wind_up;
    calm = 1'b1;
    set_all(16'h7FFF, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0001);
    send_sample(16'sd0, 1'b1);
    repeat (WIND_UP_WORDS) send_sample(16'sd0, 1'b0);
    drain;
    calm = 1'b0;
  endtask

  // Block the output for a long stretch while words keep coming
  task automatic test_back_pressure;
    calm = 1'b1;
    set_all(16'd500, 16'd90, 16'd256, 16'd384, 16'd10, 16'd10);
    hold_left = HOLD_CYCLES;
    run_move;
    run_move;
    drain;
    wait (hold_left == 0);
    calm = 1'b0;
  endtask

  // Random phases: mostly well-formed moves, some stray words
  task automatic test_random_moves;
    int stop_at;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      calm = (ph == 3);
      if (ph == 0)
        set_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
      else if (ph == PHASE_COUNT - 1)
        set_all(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
      else
        set_all(pick_target(), pick_gain(), pick_gain(), pick_gain(), pick_band(),
                pick_slow());
      stop_at = words_sent + PHASE_WORDS;
      while (words_sent < stop_at) begin
        if ($urandom_range(99) < 80)
          run_move;
        else
          send_sample(16'($urandom), $urandom_range(7) == 0);
      end
      drain;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    tgt_angle   = TARGET_ANGLE_RST;
    kp_gain     = PROP_GAIN_RST;
    ki_gain     = INTEG_GAIN_RST;
    kd_gain     = DERIV_GAIN_RST;
    band        = SETTLE_BAND_RST;
    slow_lim    = SLOW_LIMIT_RST;
    prev_angle  = '0;
    integ_count = '0;
    move_over   = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_idle_after_reset;
    test_settle_sequence;
    test_drive_saturation;
    test_truncation;
    test_back_pressure;
    test_random_moves;
    test_integral_wind_up;
    drain;
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Give up long after the slowest correct run would have finished
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* gyro_turn_pid_controller_unit.f */
+incdir+sv
sv/gtp_pkg.sv
sv/gtp_cfg_regs.sv
sv/gtp_step.sv
sv/gyro_turn_pid_controller_unit.sv
test/testbench.sv
